// File: rtl/gyro_agitation_fall_detector_assert.svh
// Assertion macros for the gyro agitation and fall detector.
`ifndef GYRO_AGITATION_FALL_DETECTOR_ASSERT_SVH
`define GYRO_AGITATION_FALL_DETECTOR_ASSERT_SVH

// Same-cycle implication.
`define GAF_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define GAF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/gaf_pkg.sv
// Shared types and constants of the gyro agitation and fall detector.
package gaf_pkg;

    typedef struct packed {
        logic signed [15:0] rate_x;
        logic signed [15:0] rate_y;
        logic signed [15:0] rate_z;
        logic [31:0]        stamp_ms;
    } t_in_item;

    typedef struct packed {
        logic agitation_event;
        logic fall_event;
    } t_out_item;

    // Classified sample handed from the front end to the detectors.
    typedef struct packed {
        logic        high;
        logic        still;
        logic [31:0] stamp_ms;
    } t_cls;

    typedef struct packed {
        logic [31:0] agitation_hold_ms;
        logic [31:0] stillness_hold_ms;
    } t_hold_cfg;

    typedef enum logic [1:0] {
        REG_HIGH_THR   = 2'd0,
        REG_STILL_THR  = 2'd1,
        REG_AGIT_HOLD  = 2'd2,
        REG_STILL_HOLD = 2'd3
    } t_reg_idx;

    localparam logic [15:0] HIGH_THR_RST   = 16'd26200;
    localparam logic [15:0] STILL_THR_RST  = 16'd1310;
    localparam logic [31:0] AGIT_HOLD_RST  = 32'd1000;
    localparam logic [31:0] STILL_HOLD_RST = 32'd2000;
    localparam logic [31:0] HIGH_SQ_RST    = 32'd686440000;
    localparam logic [31:0] STILL_SQ_RST   = 32'd1716100;

endpackage

// File: rtl/gaf_front.sv
// Front end: squares the axes, sums them and classifies the level.
module gaf_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  gaf_pkg::t_in_item i_item,
    input  logic [31:0]       i_high_sq,
    input  logic [31:0]       i_still_sq,
    output logic              o_push,
    output gaf_pkg::t_cls     o_cls
);

    logic               r_vld;
    logic [30:0]        r_sq_x;
    logic [30:0]        r_sq_y;
    logic [30:0]        r_sq_z;
    logic [31:0]        r_stamp;
    logic signed [31:0] w_px;
    logic signed [31:0] w_py;
    logic signed [31:0] w_pz;
    logic [31:0]        w_mag2;

    assign w_px = 32'(i_item.rate_x) * 32'(i_item.rate_x);
    assign w_py = 32'(i_item.rate_y) * 32'(i_item.rate_y);
    assign w_pz = 32'(i_item.rate_z) * 32'(i_item.rate_z);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= i_accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_sq_x  <= w_px[30:0];
            r_sq_y  <= w_py[30:0];
            r_sq_z  <= w_pz[30:0];
            r_stamp <= i_item.stamp_ms;
        end
    end

    // Three squares of at most 2^30 each stay below 2^32.
    assign w_mag2 = {1'b0, r_sq_x} + {1'b0, r_sq_y} + {1'b0, r_sq_z};

    assign o_push         = r_vld;
    assign o_cls.high     = w_mag2 > i_high_sq;
    assign o_cls.still    = w_mag2 < i_still_sq;
    assign o_cls.stamp_ms = r_stamp;

endmodule

// File: rtl/gaf_fifo.sv
// Short queue of classified samples between front end and detectors.
module gaf_fifo #(
    parameter int DEPTH = 4
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_push,
    input  gaf_pkg::t_cls                i_data,
    input  logic                         i_pop,
    output logic                         o_vld,
    output gaf_pkg::t_cls                o_data,
    output logic [$clog2(DEPTH+1)-1:0]   o_count
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    gaf_pkg::t_cls r_mem [DEPTH];
    logic [AW-1:0] r_wr_ptr;
    logic [AW-1:0] r_rd_ptr;
    logic [CW-1:0] r_count;
    logic [AW-1:0] n_wr_ptr;
    logic [AW-1:0] n_rd_ptr;
    logic [CW-1:0] n_count;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    assign o_vld   = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign o_count = r_count;

endmodule

// File: rtl/gaf_back.sv
// Back end: agitation and fall timers with the output register.
module gaf_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_vld,
    input  gaf_pkg::t_cls       i_cls,
    input  gaf_pkg::t_hold_cfg  i_cfg,
    input  logic                i_out_ready,
    output logic                o_pop,
    output logic                o_out_valid,
    output gaf_pkg::t_out_item  o_out_data
);

    logic                r_agit_active;
    logic [31:0]         r_agit_start;
    logic                r_fall_armed;
    logic                r_still_timing;
    logic [31:0]         r_still_start;
    logic                r_out_vld;
    gaf_pkg::t_out_item  r_out;

    logic                n_agit_active;
    logic [31:0]         n_agit_start;
    logic                n_fall_armed;
    logic                n_still_timing;
    logic [31:0]         n_still_start;
    logic                n_out_vld;
    gaf_pkg::t_out_item  n_out;

    logic                w_pop;
    logic [31:0]         w_agit_el;
    logic [31:0]         w_still_el;

    // Advance when the output register is empty or being drained.
    assign w_pop      = i_vld && (!r_out_vld || i_out_ready);
    assign w_agit_el  = i_cls.stamp_ms - r_agit_start;
    assign w_still_el = i_cls.stamp_ms - r_still_start;

    always_comb begin
        n_agit_active  = r_agit_active;
        n_agit_start   = r_agit_start;
        n_fall_armed   = r_fall_armed;
        n_still_timing = r_still_timing;
        n_still_start  = r_still_start;
        n_out          = r_out;
        n_out_vld      = r_out_vld && !i_out_ready;
        if (w_pop) begin
            n_out_vld  = 1'b1;
            n_out      = '0;
            if (i_cls.high) begin
                if (!r_agit_active) begin
                    n_agit_active = 1'b1;
                    n_agit_start  = i_cls.stamp_ms;
                end else if (w_agit_el >= i_cfg.agitation_hold_ms) begin
                    n_agit_active         = 1'b0;
                    n_out.agitation_event = 1'b1;
                end
            end else begin
                n_agit_active = 1'b0;
                n_agit_start  = '0;
            end

            if (i_cls.high) begin
                n_fall_armed   = 1'b1;
                n_still_timing = 1'b0;
            end else if (r_fall_armed) begin
                if (i_cls.still) begin
                    if (!r_still_timing) begin
                        n_still_timing = 1'b1;
                        n_still_start  = i_cls.stamp_ms;
                    end else if (w_still_el >= i_cfg.stillness_hold_ms) begin
                        n_fall_armed     = 1'b0;
                        n_out.fall_event = 1'b1;
                    end
                end else begin
                    n_still_timing = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_agit_active  <= 1'b0;
            r_agit_start   <= '0;
            r_fall_armed   <= 1'b0;
            r_still_timing <= 1'b0;
            r_still_start  <= '0;
            r_out_vld      <= 1'b0;
        end else begin
            r_agit_active  <= n_agit_active;
            r_agit_start   <= n_agit_start;
            r_fall_armed   <= n_fall_armed;
            r_still_timing <= n_still_timing;
            r_still_start  <= n_still_start;
            r_out_vld      <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_pop       = w_pop;
    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

endmodule

// File: rtl/gyro_agitation_fall_detector.sv
// Path: the square stage registers each accepted sample, the queue holds it, and the timer
// update in the back end loads the output register, where the result waits to be taken.
// Throughput: one sample per clock while results are taken; the back-end timer update handles
// a queued item a cycle unless output is stalled; QUEUE_DEPTH entries absorb output stalls.
// Reset (i_rst_n low, synchronous): timers and flags cleared, queue emptied,
// thresholds and hold times back to their defaults.
module gyro_agitation_fall_detector #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  gaf_pkg::t_in_item  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output gaf_pkg::t_out_item o_out_data,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    `include "gyro_agitation_fall_detector_assert.svh"

    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    logic [15:0]        r_high_thr;
    logic [15:0]        r_still_thr;
    logic [31:0]        r_agit_hold;
    logic [31:0]        r_still_hold;
    logic [31:0]        r_high_sq;
    logic [31:0]        r_still_sq;

    logic               w_cfg_wr;
    logic               w_in_acc;
    logic               w_push;
    gaf_pkg::t_cls      w_push_cls;
    logic               w_pop;
    logic               w_q_vld;
    gaf_pkg::t_cls      w_q_cls;
    logic [CW-1:0]      w_q_count;
    logic [CW:0]        w_fill;
    gaf_pkg::t_hold_cfg w_hold_cfg;
    gaf_pkg::t_reg_idx  w_idx;

    assign pready   = 1'b1;
    assign w_idx    = gaf_pkg::t_reg_idx'(paddr[3:2]);
    assign w_cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_high_thr   <= gaf_pkg::HIGH_THR_RST;
            r_still_thr  <= gaf_pkg::STILL_THR_RST;
            r_agit_hold  <= gaf_pkg::AGIT_HOLD_RST;
            r_still_hold <= gaf_pkg::STILL_HOLD_RST;
            r_high_sq    <= gaf_pkg::HIGH_SQ_RST;
            r_still_sq   <= gaf_pkg::STILL_SQ_RST;
        end else begin
            r_high_sq  <= 32'(r_high_thr) * 32'(r_high_thr);
            r_still_sq <= 32'(r_still_thr) * 32'(r_still_thr);
            if (w_cfg_wr) begin
                unique case (w_idx)
                    gaf_pkg::REG_HIGH_THR:   r_high_thr   <= pwdata[15:0];
                    gaf_pkg::REG_STILL_THR:  r_still_thr  <= pwdata[15:0];
                    gaf_pkg::REG_AGIT_HOLD:  r_agit_hold  <= pwdata;
                    gaf_pkg::REG_STILL_HOLD: r_still_hold <= pwdata;
                    default: ;
                endcase
            end
        end
    end

    always_comb begin
        unique case (w_idx)
            gaf_pkg::REG_HIGH_THR:   prdata = {16'd0, r_high_thr};
            gaf_pkg::REG_STILL_THR:  prdata = {16'd0, r_still_thr};
            gaf_pkg::REG_AGIT_HOLD:  prdata = r_agit_hold;
            gaf_pkg::REG_STILL_HOLD: prdata = r_still_hold;
            default:                 prdata = '0;
        endcase
    end

    assign w_hold_cfg.agitation_hold_ms = r_agit_hold;
    assign w_hold_cfg.stillness_hold_ms = r_still_hold;

    // Count the sample in the square stage against the queue space.
    assign w_fill     = (CW+1)'(w_q_count) + (CW+1)'(w_push);
    assign o_in_ready = w_fill < (CW+1)'(QUEUE_DEPTH);
    assign w_in_acc   = i_in_valid && o_in_ready;

    gaf_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (w_in_acc),
        .i_item     (i_in_data),
        .i_high_sq  (r_high_sq),
        .i_still_sq (r_still_sq),
        .o_push     (w_push),
        .o_cls      (w_push_cls)
    );

    gaf_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_push_cls),
        .i_pop   (w_pop),
        .o_vld   (w_q_vld),
        .o_data  (w_q_cls),
        .o_count (w_q_count)
    );

    gaf_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_vld       (w_q_vld),
        .i_cls       (w_q_cls),
        .i_cfg       (w_hold_cfg),
        .i_out_ready (i_out_ready),
        .o_pop       (w_pop),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

    `GAF_ASSERT_NOW(a_queue_bound, i_clk, i_rst_n, 1'b1, (w_fill <= (CW+1)'(QUEUE_DEPTH)), "queue overflow")
    `GAF_ASSERT_NEXT(a_accept_to_front, i_clk, i_rst_n, w_in_acc, w_push, "accepted sample lost before queue")
    `GAF_ASSERT_NOW(a_one_event, i_clk, i_rst_n, o_out_valid, !(o_out_data.agitation_event && o_out_data.fall_event), "agitation and fall on one sample")

endmodule

// File: tb/gaf_event_checker.sv
// Checker for the gyro agitation and fall detector: predicts each result and compares.
module gaf_event_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_ready,
    input  gaf_pkg::t_in_item  i_in_data,
    input  logic               i_out_valid,
    input  logic               i_out_ready,
    input  gaf_pkg::t_out_item i_out_data,
    input  logic               i_psel,
    input  logic               i_penable,
    input  logic               i_pwrite,
    input  logic               i_pready,
    input  logic [3:0]         i_paddr,
    input  logic [31:0]        i_pwdata,
    output int                 o_errors,
    output int                 o_outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    // Shadow copy of the configuration registers
    logic [15:0] cfg_high_thr;
    logic [15:0] cfg_still_thr;
    logic [31:0] cfg_agit_hold;
    logic [31:0] cfg_still_hold;

    // Detector state
    logic        agit_timing;
    logic [31:0] agit_t0;
    logic        fall_primed;
    logic        quiet_timing;
    logic [31:0] quiet_t0;

    gaf_pkg::t_out_item pending_events[$];
    gaf_pkg::t_out_item want;

    initial o_errors = 0;
    initial o_outstanding = 0;

    function automatic gaf_pkg::t_out_item predict_events(input gaf_pkg::t_in_item s);
        longint             ax, ay, az;
        longint unsigned    energy;
        longint unsigned    hi_sq;
        longint unsigned    lo_sq;
        logic               is_high;
        logic               is_still;
        logic [31:0]        elapsed;
        gaf_pkg::t_out_item ev;
        ax = longint'(s.rate_x);
        ay = longint'(s.rate_y);
        az = longint'(s.rate_z);
        energy = ax * ax + ay * ay + az * az;
        hi_sq = {48'd0, cfg_high_thr};
        hi_sq = hi_sq * hi_sq;
        lo_sq = {48'd0, cfg_still_thr};
        lo_sq = lo_sq * lo_sq;
        is_high = energy > hi_sq;
        is_still = energy < lo_sq;
        ev = '0;

        if (is_high) begin
            if (!agit_timing) begin
                agit_timing = 1'b1;
                agit_t0 = s.stamp_ms;
            end else begin
                elapsed = s.stamp_ms - agit_t0;
                if (elapsed >= cfg_agit_hold) begin
                    agit_timing = 1'b0;
                    ev.agitation_event = 1'b1;
                end
            end
        end else begin
            agit_timing = 1'b0;
            agit_t0 = '0;
        end

        // A high sample re-arms the fall detector and restarts the quiet interval
        if (is_high) begin
            fall_primed = 1'b1;
            quiet_timing = 1'b0;
        end else if (fall_primed) begin
            if (is_still) begin
                if (!quiet_timing) begin
                    quiet_timing = 1'b1;
                    quiet_t0 = s.stamp_ms;
                end else begin
                    elapsed = s.stamp_ms - quiet_t0;
                    if (elapsed >= cfg_still_hold) begin
                        fall_primed = 1'b0;
                        ev.fall_event = 1'b1;
                    end
                end
            end else begin
                quiet_timing = 1'b0;
            end
        end
        return ev;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cfg_high_thr = gaf_pkg::HIGH_THR_RST;
            cfg_still_thr = gaf_pkg::STILL_THR_RST;
            cfg_agit_hold = gaf_pkg::AGIT_HOLD_RST;
            cfg_still_hold = gaf_pkg::STILL_HOLD_RST;
            agit_timing = 1'b0;
            agit_t0 = '0;
            fall_primed = 1'b0;
            quiet_timing = 1'b0;
            quiet_t0 = '0;
            pending_events.delete();
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (gaf_pkg::t_reg_idx'(i_paddr[3:2]))
                    gaf_pkg::REG_HIGH_THR:   cfg_high_thr = i_pwdata[15:0];
                    gaf_pkg::REG_STILL_THR:  cfg_still_thr = i_pwdata[15:0];
                    gaf_pkg::REG_AGIT_HOLD:  cfg_agit_hold = i_pwdata;
                    gaf_pkg::REG_STILL_HOLD: cfg_still_hold = i_pwdata;
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready) begin
                pending_events.push_back(predict_events(i_in_data));
            end
            if (i_out_valid && i_out_ready) begin
                if (pending_events.size() == 0) begin
                    $display("%0t: result with nothing expected, agitation %0b fall %0b",
                             $realtime, i_out_data.agitation_event, i_out_data.fall_event);
                    o_errors++;
                end else begin
                    want = pending_events.pop_front();
                    if (i_out_data.agitation_event !== want.agitation_event) begin
                        $display("%0t: agitation_event expected %0b got %0b", $realtime,
                                 want.agitation_event, i_out_data.agitation_event);
                        o_errors++;
                    end
                    if (i_out_data.fall_event !== want.fall_event) begin
                        $display("%0t: fall_event expected %0b got %0b", $realtime,
                                 want.fall_event, i_out_data.fall_event);
                        o_errors++;
                    end
                end
            end
        end
        o_outstanding <= pending_events.size();
    end

endmodule

// File: tb/gyro_agitation_fall_detector_test.sv
// Testbench top for the gyro agitation and fall detector: stimulus, idling and verdict.
module gyro_agitation_fall_detector_test;
    timeunit 1ns;
    timeprecision 1ps;

    typedef enum {LVL_HIGH, LVL_STILL, LVL_MID, LVL_NOISE} t_level;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_in_valid = 1'b0;
    logic               o_in_ready;
    gaf_pkg::t_in_item  i_in_data = '0;
    logic               o_out_valid;
    logic               i_out_ready = 1'b0;
    gaf_pkg::t_out_item o_out_data;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [3:0]         paddr = '0;
    logic [31:0]        pwdata = '0;
    logic [31:0]        prdata;
    logic               pready;

    int fail_count;
    int outstanding;

    int unsigned send_idle_pct = 0;
    int unsigned ready_stall_pct = 0;
    int unsigned holdoff_ask = 0;
    int unsigned holdoff_seen = 0;
    int unsigned holdoff_left = 0;
    int unsigned samples_sent = 0;

    logic [15:0] thr_high_now = gaf_pkg::HIGH_THR_RST;
    logic [15:0] thr_still_now = gaf_pkg::STILL_THR_RST;
    logic [31:0] clock_ms = '0;

    gyro_agitation_fall_detector dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    gaf_event_checker checker_i (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .i_in_ready    (o_in_ready),
        .i_in_data     (i_in_data),
        .i_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .i_out_data    (o_out_data),
        .i_psel        (psel),
        .i_penable     (penable),
        .i_pwrite      (pwrite),
        .i_pready      (pready),
        .i_paddr       (paddr),
        .i_pwdata      (pwdata),
        .o_errors      (fail_count),
        .o_outstanding (outstanding)
    );

    always #4 i_clk = ~i_clk;

    initial begin
        #2_000_000;
        $display("gyro_agitation_fall_detector verification failed");
        $finish;
    end

    // Receiver: random stalls, plus a long hold-off whenever one is asked for
    always @(posedge i_clk) begin
        if (holdoff_ask != holdoff_seen) begin
            holdoff_seen = holdoff_ask;
            holdoff_left = 150;
        end
        if (holdoff_left > 0) begin
            holdoff_left--;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= ready_stall_pct);
        end
    end

    function automatic logic signed [15:0] pick_axis(input int unsigned amp_lo,
                                                     input int unsigned amp_hi);
        int unsigned        amp;
        logic signed [15:0] v;
        if (amp_hi > 32768) amp_hi = 32768;
        if (amp_lo > amp_hi) amp_lo = amp_hi;
        amp = $urandom_range(amp_hi, amp_lo);
        if (amp >= 32768) begin
            v = 16'sh8000;
        end else begin
            v = amp[15:0];
            if ($urandom_range(1)) v = -v;
        end
        return v;
    endfunction

    function automatic t_level level_of(input gaf_pkg::t_in_item s);
        longint ax, ay, az, energy, hs, ls;
        ax = longint'(s.rate_x);
        ay = longint'(s.rate_y);
        az = longint'(s.rate_z);
        energy = ax * ax + ay * ay + az * az;
        hs = longint'(thr_high_now) * longint'(thr_high_now);
        ls = longint'(thr_still_now) * longint'(thr_still_now);
        if (energy > hs) return LVL_HIGH;
        if (energy < ls) return LVL_STILL;
        return LVL_MID;
    endfunction

    // Draw axes until the sample lands in the wanted level band; keep the last try otherwise
    function automatic gaf_pkg::t_in_item shape_sample(input t_level want);
        gaf_pkg::t_in_item s;
        int unsigned       tries;
        logic              done;
        s = '0;
        tries = 0;
        done = 1'b0;
        while (!done && tries < 64) begin
            case (want)
                LVL_HIGH: begin
                    s.rate_x = pick_axis(32'(thr_high_now) / 2, 32768);
                    s.rate_y = pick_axis(32'(thr_high_now) / 2, 32768);
                    s.rate_z = pick_axis(32'(thr_high_now) / 2, 32768);
                end
                LVL_STILL: begin
                    s.rate_x = pick_axis(0, 32'(thr_still_now) / 2);
                    s.rate_y = pick_axis(0, 32'(thr_still_now) / 2);
                    s.rate_z = pick_axis(0, 32'(thr_still_now) / 2);
                end
                LVL_MID: begin
                    s.rate_x = pick_axis(0, 32'(thr_high_now));
                    s.rate_y = pick_axis(0, 32'(thr_high_now));
                    s.rate_z = pick_axis(0, 32'(thr_high_now));
                end
                default: begin
                    s.rate_x = 16'($urandom);
                    s.rate_y = 16'($urandom);
                    s.rate_z = 16'($urandom);
                end
            endcase
            done = (want == LVL_NOISE) || (level_of(s) == want);
            tries++;
        end
        return s;
    endfunction

    // Offer one transaction; valid stays high back to back when the sender does not idle
    task automatic send_item(input gaf_pkg::t_in_item s);
        if ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        i_in_valid <= 1'b1;
        i_in_data <= s;
        do @(posedge i_clk); while (!o_in_ready);
        samples_sent++;
    endtask

    task automatic send_at(input logic signed [15:0] x, input logic signed [15:0] y,
                           input logic signed [15:0] z, input logic [31:0] stamp);
        gaf_pkg::t_in_item s;
        s.rate_x = x;
        s.rate_y = y;
        s.rate_z = z;
        s.stamp_ms = stamp;
        send_item(s);
    endtask

    task automatic put_sample(input t_level want, input int unsigned step);
        gaf_pkg::t_in_item s;
        clock_ms = clock_ms + $urandom_range(step, 0);
        s = shape_sample(want);
        s.stamp_ms = clock_ms;
        send_item(s);
    endtask

    // Hold the sender until every result is back, then let the pipeline empty
    task automatic drain_results();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (outstanding != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic reg_write(input gaf_pkg::t_reg_idx idx, input logic [31:0] val);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic configure(input logic [15:0] hi_thr, input logic [15:0] lo_thr,
                             input logic [31:0] agit_hold, input logic [31:0] still_hold);
        drain_results();
        reg_write(gaf_pkg::REG_HIGH_THR, {16'd0, hi_thr});
        reg_write(gaf_pkg::REG_STILL_THR, {16'd0, lo_thr});
        reg_write(gaf_pkg::REG_AGIT_HOLD, agit_hold);
        reg_write(gaf_pkg::REG_STILL_HOLD, still_hold);
        thr_high_now = hi_thr;
        thr_still_now = lo_thr;
    endtask

    // Mostly motion bursts followed by settling, with broken settles and noise mixed in
    task automatic run_random(input int unsigned n, input int unsigned step);
        int unsigned goal;
        int unsigned pick;
        goal = samples_sent + n;
        while (samples_sent < goal) begin
            pick = $urandom_range(9);
            if (pick < 6) begin
                repeat ($urandom_range(10, 1)) put_sample(LVL_HIGH, step);
                if ($urandom_range(3) == 0) put_sample(LVL_MID, step);
                repeat ($urandom_range(10, 1)) put_sample(LVL_STILL, step);
            end else if (pick < 8) begin
                repeat ($urandom_range(14, 2)) put_sample(LVL_HIGH, step);
            end else if (pick == 8) begin
                if ($urandom_range(1)) clock_ms = $urandom;
                else clock_ms = 32'hFFFF_FFFF - $urandom_range(200);
                put_sample(LVL_NOISE, 0);
            end else begin
                put_sample(LVL_MID, step);
            end
        end
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset defaults: zero stamp, strict compares at the thresholds, wrap of elapsed time
        send_at(16'sd0, 16'sd0, 16'sd0, 32'd0);
        send_at(16'sd32767, 16'sd32767, 16'sd32767, 32'd0);
        send_at(-16'sd32768, -16'sd32768, -16'sd32768, 32'd999);
        send_at(-16'sd32768, 16'sd0, 16'sd0, 32'd1000);
        send_at(16'sd26200, 16'sd0, 16'sd0, 32'd1500);
        send_at(16'sd26201, 16'sd0, 16'sd0, 32'd1600);
        send_at(16'sd1309, 16'sd0, 16'sd0, 32'd1700);
        send_at(16'sd1310, 16'sd0, 16'sd0, 32'd1800);
        send_at(16'sd0, 16'sd0, -16'sd1309, 32'd1900);
        send_at(16'sd0, 16'sd5, 16'sd0, 32'd3899);
        send_at(16'sd0, 16'sd0, 16'sd0, 32'd3900);
        send_at(16'sd0, 16'sd0, 16'sd0, 32'd6000);
        send_at(16'sd30000, 16'sd0, 16'sd0, 32'd6001);
        send_at(16'sd0, 16'sd30000, 16'sd0, 32'hFFFF_FC00);
        send_at(16'sd0, 16'sd0, -16'sd30000, 32'hFFFF_FF00);
        send_at(16'sd30000, 16'sd0, 16'sd0, 32'h0000_02E7);
        send_at(16'sd30000, 16'sd0, 16'sd0, 32'h0000_02E8);
        send_at(16'sd100, -16'sd100, 16'sd100, 32'h0000_0300);
        send_at(16'sd100, -16'sd100, 16'sd100, 32'h0000_0AD0);

        // Zero high threshold, top still threshold and zero hold times: fire on the very next sample
        configure(16'd0, 16'hFFFF, 32'd0, 32'd0);
        send_at(16'sd0, 16'sd0, 16'sd0, 32'h1234_5678);
        send_at(16'sd1, 16'sd0, 16'sd0, 32'h1234_5678);
        send_at(16'sd0, 16'sd0, 16'sd1, 32'h1234_5678);
        send_at(16'sd0, 16'sd0, 16'sd0, 32'h1234_5678);
        send_at(16'sd0, 16'sd0, 16'sd0, 32'h1234_5678);

        // Top of the threshold range and maximum hold times
        configure(16'd56756, 16'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_at(-16'sd32768, -16'sd32768, -16'sd32768, 32'd50);
        configure(16'd56755, 16'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_at(-16'sd32768, -16'sd32768, -16'sd32768, 32'd100);
        send_at(-16'sd32768, -16'sd32768, -16'sd32768, 32'd99);

        configure(16'd20000, 16'd3000, 32'd60, 32'd120);
        clock_ms = $urandom;
        run_random(170, 30);

        configure(16'd12000, 16'd6000, 32'd0, 32'd5);
        send_idle_pct = 80;
        run_random(120, 10);

        configure(16'd30000, 16'd500, 32'd200, 32'd300);
        send_idle_pct = 0;
        ready_stall_pct = 80;
        run_random(120, 60);

        configure(gaf_pkg::HIGH_THR_RST, gaf_pkg::STILL_THR_RST,
                  gaf_pkg::AGIT_HOLD_RST, gaf_pkg::STILL_HOLD_RST);
        send_idle_pct = 13;
        ready_stall_pct = 13;
        holdoff_ask++;
        run_random(60, 300);
        drain_results();
        run_random(70, 300);

        // Still threshold above the range: every calm sample counts as still
        configure(16'd4000, 16'hFFFF, 32'hFFFF_FFF0, 32'h8000_0000);
        send_idle_pct = 0;
        ready_stall_pct = 0;
        run_random(80, 32'hFFFF_FFFF);

        drain_results();
        repeat (10) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("gyro_agitation_fall_detector verification clean");
        end else begin
            $display("gyro_agitation_fall_detector verification failed");
        end
        $finish;
    end

endmodule
